[rtl/utf8dw_pkg.sv]
// ----------------------------------------------------------------------------
// utf8dw_pkg
// Shared types, constants and width tables of the UTF-8 display width counter.
// ----------------------------------------------------------------------------
package utf8dw_pkg;

    // default width of the running column count
    localparam int unsigned COUNT_BITS_DEF = 16;
    // width of the column count carried on the result beat
    localparam int unsigned WIDTH_OUT_BITS = 16;
    // code point width
    localparam int unsigned CP_BITS        = 21;

    localparam logic [7:0] ESC_BYTE = 8'h1B;
    localparam logic [7:0] CSI_BYTE = 8'h5B;

    // escape sequence tracker
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ESC,
        PH_PARAM,
        PH_INTER
    } t_esc_phase;

    // input beat: one byte of the string
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_beat;

    // result beat: width of the whole string
    typedef struct packed {
        logic [WIDTH_OUT_BITS-1:0] column_width;
        logic                      width_saturated;
    } t_out_beat;

    // width of a lone byte taken as its own code point
    function automatic logic [1:0] byte_width(input logic [7:0] b);
        logic zero;
        zero = (b inside {[8'h00:8'h1F], [8'h7F:8'h9F]});
        return zero ? 2'd0 : 2'd1;
    endfunction

    // console column width of one code point
    function automatic logic [1:0] cell_width(input logic [CP_BITS-1:0] c);
        logic zero;
        logic wide;
        zero = (c inside {[21'h00000:21'h0001F], [21'h0007F:21'h0009F],
                          [21'h00300:21'h0036F], [21'h01AB0:21'h01AFF],
                          [21'h01DC0:21'h01DFF], [21'h020D0:21'h020FF],
                          [21'h0FE20:21'h0FE2F], [21'h0FE0E:21'h0FE0F],
                          [21'h1F3FB:21'h1F3FF], 21'h0200D});
        wide = (c inside {[21'h01100:21'h0115F], [21'h02329:21'h0232A],
                          [21'h0231A:21'h0231B], [21'h023E9:21'h023F3],
                          [21'h023F8:21'h023FA], [21'h025AA:21'h025AB],
                          [21'h025B6:21'h025C0], [21'h025FB:21'h025FE],
                          [21'h02600:21'h026FF], [21'h02700:21'h027BF],
                          [21'h02934:21'h02935], [21'h02B05:21'h02B07],
                          [21'h02B1B:21'h02B1C], 21'h02B50, 21'h02B55,
                          [21'h02E80:21'h0303E], [21'h03040:21'h0A4CF],
                          [21'h0AC00:21'h0D7A3], [21'h0F900:21'h0FAFF],
                          [21'h0FE10:21'h0FE1F], [21'h0FE30:21'h0FE6F],
                          [21'h0FF00:21'h0FF60], [21'h0FFE0:21'h0FFE6],
                          [21'h1F1E6:21'h1F1FF], [21'h1F300:21'h1F64F],
                          [21'h1F680:21'h1F6FF], [21'h1F900:21'h1F9FF],
                          [21'h1FA00:21'h1FAFF], [21'h20000:21'h2FFFF]});
        if (zero) begin
            return 2'd0;
        end else if (wide) begin
            return 2'd2;
        end
        return 2'd1;
    endfunction

    // pad a partial code point with zero payload for the missing bytes
    function automatic logic [CP_BITS-1:0] pad_cp(input logic [CP_BITS-1:0] c,
                                                  input logic [1:0]         rem);
        logic [CP_BITS-1:0] r;
        case (rem)
            2'd0:    r = c;
            2'd1:    r = {c[CP_BITS-7:0], 6'b0};
            2'd2:    r = {c[CP_BITS-13:0], 12'b0};
            2'd3:    r = {c[CP_BITS-19:0], 18'b0};
            default: r = c;
        endcase
        return r;
    endfunction

endpackage

[rtl/utf8dw_in_reg.sv]
// ----------------------------------------------------------------------------
// utf8dw_in_reg
// Input register: holds one byte beat until the width core takes it.
// ----------------------------------------------------------------------------
module utf8dw_in_reg
    import utf8dw_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_beat i_beat,
    output logic     o_stall,
    input  logic     i_consume,
    output logic     o_valid,
    output t_in_beat o_beat
);

    logic     r_valid;
    logic     n_valid;
    t_in_beat r_beat;
    logic     load;

    // take a new beat whenever the register is empty or drains this cycle
    assign o_stall = r_valid && !i_consume;
    assign load    = i_valid && !o_stall;
    assign n_valid = load || (r_valid && !i_consume);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_beat <= i_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

[rtl/utf8dw_core.sv]
// ----------------------------------------------------------------------------
// utf8dw_core
// Per-byte decode: UTF-8 assembly, CSI skipping and saturating width count.
// ----------------------------------------------------------------------------
module utf8dw_core
    import utf8dw_pkg::*;
#(
    parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_beat  i_beat,
    output logic      o_consume,
    input  logic      i_out_busy,
    output logic      o_res_valid,
    output t_out_beat o_res
);

    localparam int unsigned SUM_BITS = COUNT_BITS + 2;
    localparam logic [COUNT_BITS-1:0] LIMIT = '1;

    logic [1:0]            r_bytes_rem;
    logic [1:0]            n_bytes_rem;
    logic [CP_BITS-1:0]    r_cp_acc;
    logic [CP_BITS-1:0]    n_cp_acc;
    t_esc_phase            r_phase;
    t_esc_phase            n_phase;
    logic [COUNT_BITS-1:0] r_pending;
    logic [COUNT_BITS-1:0] n_pending;
    logic [COUNT_BITS-1:0] r_total;
    logic [COUNT_BITS-1:0] n_total;
    logic                  r_sat;
    logic                  n_sat;

    logic [COUNT_BITS-1:0]                pend_bump;
    logic [COUNT_BITS-1:0]                flush_w;
    logic [COUNT_BITS-1:0]                end_w;
    logic [1:0]                           byte_w;
    logic [1:0]                           cp_w;
    logic                                 taken;
    logic                                 cp_check;
    logic [SUM_BITS-1:0]                  sum;
    logic                                 hit_limit;
    logic [COUNT_BITS+WIDTH_OUT_BITS-1:0] total_ext;
    logic [7:0]                           b;
    logic                                 last;

    assign b    = i_beat.data_byte;
    assign last = i_beat.last_byte;

    // a final byte waits only while the result register is still held
    assign o_consume = i_valid && !(last && i_out_busy);

    assign pend_bump = (r_pending == LIMIT) ? r_pending : r_pending + 1'b1;

    // next state for one byte
    always_comb begin
        n_bytes_rem = r_bytes_rem;
        n_cp_acc    = r_cp_acc;
        n_phase     = r_phase;
        n_pending   = r_pending;
        flush_w     = '0;
        byte_w      = 2'd0;
        taken       = 1'b0;

        if (r_bytes_rem != 2'd0) begin
            // continuation byte, taken blindly
            n_cp_acc    = {r_cp_acc[CP_BITS-7:0], b[5:0]};
            n_bytes_rem = r_bytes_rem - 2'd1;
        end else begin
            // escape sequence tracking
            case (r_phase)
                PH_ESC: begin
                    if (b == CSI_BYTE) begin
                        n_phase   = PH_PARAM;
                        n_pending = pend_bump;
                        taken     = 1'b1;
                    end else begin
                        flush_w   = r_pending;
                        n_pending = '0;
                        n_phase   = PH_IDLE;
                    end
                end
                PH_PARAM, PH_INTER: begin
                    if (r_phase == PH_PARAM && (b inside {[8'h30:8'h3F]})) begin
                        n_pending = pend_bump;
                        taken     = 1'b1;
                    end else if (b inside {[8'h20:8'h2F]}) begin
                        n_phase   = PH_INTER;
                        n_pending = pend_bump;
                        taken     = 1'b1;
                    end else if (b inside {[8'h40:8'h7E]}) begin
                        n_phase   = PH_IDLE;
                        n_pending = '0;
                        taken     = 1'b1;
                    end else begin
                        // broken csi: its bytes count as text
                        flush_w   = r_pending;
                        n_pending = '0;
                        n_phase   = PH_IDLE;
                    end
                end
                default: ;
            endcase

            // ordinary byte handling
            if (!taken) begin
                if (b == ESC_BYTE) begin
                    n_phase = PH_ESC;
                end else if (b[7:5] == 3'b110) begin
                    n_cp_acc    = {{(CP_BITS-5){1'b0}}, b[4:0]};
                    n_bytes_rem = 2'd1;
                end else if (b[7:4] == 4'b1110) begin
                    n_cp_acc    = {{(CP_BITS-4){1'b0}}, b[3:0]};
                    n_bytes_rem = 2'd2;
                end else if (b[7:3] == 5'b11110) begin
                    n_cp_acc    = {{(CP_BITS-3){1'b0}}, b[2:0]};
                    n_bytes_rem = 2'd3;
                end else begin
                    byte_w = byte_width(b);
                end
            end
        end

        // completed code point, or one cut short by the end of the string
        cp_check = ((r_bytes_rem != 2'd0) && (n_bytes_rem == 2'd0)) ||
                   (last && (n_bytes_rem != 2'd0));
        cp_w     = cp_check ? cell_width(pad_cp(n_cp_acc, n_bytes_rem)) : 2'd0;
        end_w    = last ? n_pending : '0;

        // saturating total
        sum = {2'b00, r_total} + {2'b00, flush_w} + {2'b00, end_w}
            + {{COUNT_BITS{1'b0}}, byte_w} + {{COUNT_BITS{1'b0}}, cp_w};
        hit_limit = (sum >= {2'b00, LIMIT});
        n_total   = hit_limit ? LIMIT : sum[COUNT_BITS-1:0];
        n_sat     = r_sat || hit_limit;

        total_ext = {{WIDTH_OUT_BITS{1'b0}}, n_total};
        o_res.column_width    = total_ext[WIDTH_OUT_BITS-1:0];
        o_res.width_saturated = n_sat;
        o_res_valid           = o_consume && last;

        // string done: back to the reset state
        if (last) begin
            n_bytes_rem = 2'd0;
            n_cp_acc    = '0;
            n_phase     = PH_IDLE;
            n_pending   = '0;
            n_total     = '0;
            n_sat       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_rem <= 2'd0;
            r_cp_acc    <= '0;
            r_phase     <= PH_IDLE;
            r_pending   <= '0;
            r_total     <= '0;
            r_sat       <= 1'b0;
        end else if (o_consume) begin
            r_bytes_rem <= n_bytes_rem;
            r_cp_acc    <= n_cp_acc;
            r_phase     <= n_phase;
            r_pending   <= n_pending;
            r_total     <= n_total;
            r_sat       <= n_sat;
        end
    end

    // a finished string leaves the decoder clear
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_consume && last |=> r_bytes_rem == 2'd0 && r_phase == PH_IDLE &&
                              r_total == '0 && r_pending == '0 && !r_sat)
        else $error("state not cleared after last beat");

    // flag and clamped total move together
    a_sat_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sat == (r_total == LIMIT))
        else $error("saturation flag out of step with total");

    // pending width only exists inside a csi body
    a_pending_in_csi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending != '0 |-> (r_phase == PH_PARAM || r_phase == PH_INTER))
        else $error("pending width outside csi");

    // never overwrite a held result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !i_out_busy)
        else $error("result issued while output held");

endmodule

[rtl/utf8dw_out_reg.sv]
// ----------------------------------------------------------------------------
// utf8dw_out_reg
// Result register: holds the width beat until the receiver takes it.
// ----------------------------------------------------------------------------
module utf8dw_out_reg
    import utf8dw_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_res_valid,
    input  t_out_beat i_res,
    output logic      o_busy,
    output logic      o_valid,
    output t_out_beat o_beat,
    input  logic      i_stall
);

    logic      r_valid;
    logic      n_valid;
    t_out_beat r_beat;

    // held while the receiver stalls, free otherwise
    assign o_busy  = r_valid && i_stall;
    assign n_valid = i_res_valid || o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_valid) begin
            r_beat <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

[rtl/utf8_display_width_counter.sv]
// ----------------------------------------------------------------------------
// utf8_display_width_counter
// Console column width of a UTF-8 string, one byte per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid / i_in_beat / o_in_stall carries one byte per
//   beat; last_byte marks the final byte of a string. Output channel
//   o_out_valid / o_out_beat / i_out_stall carries one beat per string with
//   the saturating column width and the saturation flag.
//   Throughput is one byte per cycle while no last byte waits on a held
//   result: the per-byte decode is combinational between the input register
//   and the result register, and the state loop (code point, escape phase,
//   running total) is updated on each accepted byte. A last byte is decoded
//   from the input register into the result register, offered until taken.
//   A stall on the output holds the result; ordinary bytes keep flowing, and
//   only a next last byte waits for the held result to leave.
//   Reset (i_rst_n low, synchronous) empties both registers and clears the
//   decoder to the start of a new string.
// ----------------------------------------------------------------------------
module utf8_display_width_counter
    import utf8dw_pkg::*;
#(
    parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_beat  i_in_beat,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_beat o_out_beat,
    input  logic      i_out_stall
);

    logic      in_valid;
    t_in_beat  in_beat;
    logic      consume;
    logic      out_busy;
    logic      res_valid;
    t_out_beat res;

    // input register
    utf8dw_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_beat    (i_in_beat),
        .o_stall   (o_in_stall),
        .i_consume (consume),
        .o_valid   (in_valid),
        .o_beat    (in_beat)
    );

    // decode and count
    utf8dw_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_valid),
        .i_beat      (in_beat),
        .o_consume   (consume),
        .i_out_busy  (out_busy),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result register
    utf8dw_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_busy      (out_busy),
        .o_valid     (o_out_valid),
        .o_beat      (o_out_beat),
        .i_stall     (i_out_stall)
    );

endmodule

[verif/utf8_display_width_counter_test.sv]
// ----------------------------------------------------------------------------
// utf8_display_width_counter_test
// Self-checking bench for the UTF-8 display width counter. Byte streams of
// text, escape sequences and malformed UTF-8 go in with random gaps while the
// result side stalls at random; each string width is predicted in the bench
// and compared field by field with the result beats in order.
// ----------------------------------------------------------------------------
module utf8_display_width_counter_test
    import utf8dw_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WIDTH_MAX    = (1 << COUNT_BITS_DEF) - 1;
    localparam int unsigned RANDOM_BYTES = 1200;
    localparam int unsigned IDLE_LIMIT   = 4000;
    localparam int unsigned DRAIN_CYCLES = 8;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_beat  i_in_beat   = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_beat o_out_beat;
    logic      i_out_stall = 1'b0;

    // bytes waiting to be driven, string under construction, widths owed
    t_in_beat    byte_queue[$];
    logic [7:0]  str_buf[$];
    t_out_beat   width_expected[$];

    int unsigned err_count   = 0;
    int unsigned idle_cycles = 0;
    int unsigned hold_off    = 0;
    int unsigned stall_left  = 0;
    bit          calm_in     = 1'b0;
    bit          calm_out    = 1'b0;

    // predictor state
    logic [1:0]  cont_left;
    logic [20:0] cp_acc;
    t_esc_phase  esc_phase;
    int unsigned csi_width;
    int unsigned run_width;
    logic        run_sat;

    utf8_display_width_counter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_beat   (i_in_beat),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat),
        .i_out_stall (i_out_stall)
    );

    // clock and reset
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // width prediction
    // ------------------------------------------------------------------
    function automatic bit span(input logic [20:0] c, input int unsigned lo,
                                input int unsigned hi);
        return (c >= lo) && (c <= hi);
    endfunction

    function automatic int unsigned glyph_width(input logic [20:0] c);
        // controls, combining marks, selectors, skin tones, joiner
        if (c < 21'h20 || span(c, 'h7F, 'h9F)) return 0;
        if (span(c, 'h0300, 'h036F) || span(c, 'h1AB0, 'h1AFF) ||
            span(c, 'h1DC0, 'h1DFF) || span(c, 'h20D0, 'h20FF) ||
            span(c, 'hFE20, 'hFE2F)) return 0;
        if (c == 21'hFE0E || c == 21'hFE0F) return 0;
        if (span(c, 'h1F3FB, 'h1F3FF)) return 0;
        if (c == 21'h200D) return 0;
        // wide glyphs
        if (c >= 21'h1100 &&
            (c <= 21'h115F || span(c, 'h2329, 'h232A) ||
             span(c, 'h231A, 'h231B) || span(c, 'h23E9, 'h23F3) ||
             span(c, 'h23F8, 'h23FA) || span(c, 'h25AA, 'h25AB) ||
             span(c, 'h25B6, 'h25C0) || span(c, 'h25FB, 'h25FE) ||
             span(c, 'h2600, 'h26FF) || span(c, 'h2700, 'h27BF) ||
             span(c, 'h2934, 'h2935) || span(c, 'h2B05, 'h2B07) ||
             span(c, 'h2B1B, 'h2B1C) || c == 21'h2B50 || c == 21'h2B55 ||
             (span(c, 'h2E80, 'hA4CF) && c != 21'h303F) ||
             span(c, 'hAC00, 'hD7A3) || span(c, 'hF900, 'hFAFF) ||
             span(c, 'hFE10, 'hFE1F) || span(c, 'hFE30, 'hFE6F) ||
             span(c, 'hFF00, 'hFF60) || span(c, 'hFFE0, 'hFFE6) ||
             span(c, 'h1F1E6, 'h1F1FF) || span(c, 'h1F300, 'h1F64F) ||
             span(c, 'h1F680, 'h1F6FF) || span(c, 'h1F900, 'h1F9FF) ||
             span(c, 'h1FA00, 'h1FAFF) || span(c, 'h20000, 'h2FFFF)))
            return 2;
        return 1;
    endfunction

    function void clear_decoder();
        cont_left = 2'd0;
        cp_acc    = '0;
        esc_phase = PH_IDLE;
        csi_width = 0;
        run_width = 0;
        run_sat   = 1'b0;
    endfunction

    // saturating running total
    function void add_width(input int unsigned w);
        int unsigned s;
        s = run_width + w;
        if (s >= WIDTH_MAX) begin
            s = WIDTH_MAX;
            run_sat = 1'b1;
        end
        run_width = s;
    endfunction

    function void bump_csi();
        if (csi_width < WIDTH_MAX) csi_width = csi_width + 1;
    endfunction

    // an abandoned escape counts its bytes as ordinary characters
    function void close_escape();
        add_width(csi_width);
        csi_width = 0;
        esc_phase = PH_IDLE;
    endfunction

    // byte in lead position outside any escape
    function void take_plain(input logic [7:0] b);
        if (b == ESC_BYTE) begin
            esc_phase = PH_ESC;
        end else if (b < 8'h80) begin
            add_width(glyph_width({13'd0, b}));
        end else if (b[7:5] == 3'b110) begin
            cp_acc    = {16'd0, b[4:0]};
            cont_left = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
            cp_acc    = {17'd0, b[3:0]};
            cont_left = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
            cp_acc    = {18'd0, b[2:0]};
            cont_left = 2'd3;
        end else begin
            add_width(glyph_width({13'd0, b}));
        end
    endfunction

    // one accepted byte; returns 1 with the string width on the last byte
    function bit step_width(input t_in_beat beat, output t_out_beat res);
        logic [7:0]  b;
        logic [20:0] padded;
        bit          taken;
        b     = beat.data_byte;
        taken = 1'b0;
        res   = '0;
        if (cont_left != 2'd0) begin
            cp_acc    = {cp_acc[14:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0) add_width(glyph_width(cp_acc));
        end else begin
            if (esc_phase == PH_ESC) begin
                if (b == CSI_BYTE) begin
                    esc_phase = PH_PARAM;
                    bump_csi();
                    taken = 1'b1;
                end else begin
                    close_escape();
                end
            end else if (esc_phase == PH_PARAM || esc_phase == PH_INTER) begin
                if (esc_phase == PH_PARAM && b >= 8'h30 && b <= 8'h3F) begin
                    bump_csi();
                    taken = 1'b1;
                end else if (b >= 8'h20 && b <= 8'h2F) begin
                    esc_phase = PH_INTER;
                    bump_csi();
                    taken = 1'b1;
                end else if (b >= 8'h40 && b <= 8'h7E) begin
                    esc_phase = PH_IDLE;
                    csi_width = 0;
                    taken = 1'b1;
                end else begin
                    close_escape();
                end
            end
            if (!taken) take_plain(b);
        end
        if (!beat.last_byte) return 1'b0;
        // truncated final sequence: missing bytes give zero payload
        if (cont_left != 2'd0) begin
            padded = cp_acc << (6 * cont_left);
            add_width(glyph_width(padded));
        end
        close_escape();
        res.column_width    = run_width[15:0];
        res.width_saturated = run_sat;
        clear_decoder();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------
    task send_string();
        t_in_beat beat;
        for (int i = 0; i < str_buf.size(); i++) begin
            beat.data_byte = str_buf[i];
            beat.last_byte = (i == str_buf.size() - 1);
            byte_queue.push_back(beat);
        end
        str_buf.delete();
    endtask

    task add_cp(input logic [20:0] cp);
        if (cp < 21'h800) begin
            str_buf.push_back({3'b110, cp[10:6]});
            str_buf.push_back({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            str_buf.push_back({4'b1110, cp[15:12]});
            str_buf.push_back({2'b10, cp[11:6]});
            str_buf.push_back({2'b10, cp[5:0]});
        end else begin
            str_buf.push_back({5'b11110, cp[20:18]});
            str_buf.push_back({2'b10, cp[17:12]});
            str_buf.push_back({2'b10, cp[11:6]});
            str_buf.push_back({2'b10, cp[5:0]});
        end
    endtask

    // code points near the range boundaries or anywhere in a length class
    function automatic logic [20:0] pick_cp();
        int unsigned mark;
        case ($urandom_range(0, 13))
            0:  mark = 'h0300;
            1:  mark = 'h036F;
            2:  mark = 'h1100;
            3:  mark = 'h115F;
            4:  mark = 'h200D;
            5:  mark = 'h2E80;
            6:  mark = 'h303F;
            7:  mark = 'hA4CF;
            8:  mark = 'hFE0E;
            9:  mark = 'h1F3FB;
            10: mark = 'h20000;
            11: mark = 'h2FFFF;
            12: mark = 'hAC00;
            default: mark = 'h1F600;
        endcase
        case ($urandom_range(0, 4))
            0:       return 21'(mark);
            1:       return 21'(mark + $urandom_range(0, 2) - 1);
            2:       return 21'($urandom_range('h80, 'h7FF));
            3:       return 21'($urandom_range('h800, 'hFFFF));
            default: return 21'($urandom_range('h10000, 'h1FFFFF));
        endcase
    endfunction

    // lead byte of a multi-byte sequence and how many bytes follow it
    task add_lead(output int unsigned need);
        logic [7:0] lead;
        lead = 8'($urandom_range('hC0, 'hF7));
        need = (lead >= 8'hF0) ? 3 : (lead >= 8'hE0) ? 2 : 1;
        str_buf.push_back(lead);
    endtask

    task add_random_piece();
        int unsigned kind;
        int unsigned need;
        kind = $urandom_range(0, 99);
        if (kind < 25) begin
            str_buf.push_back(8'($urandom_range('h20, 'h7E)));
        end else if (kind < 30) begin
            str_buf.push_back(8'($urandom_range('h00, 'h7F)));
        end else if (kind < 55) begin
            add_cp(pick_cp());
        end else if (kind < 65) begin
            // well-formed escape sequence
            str_buf.push_back(ESC_BYTE);
            str_buf.push_back(CSI_BYTE);
            repeat ($urandom_range(0, 4))
                str_buf.push_back(8'($urandom_range('h30, 'h3F)));
            repeat ($urandom_range(0, 2))
                str_buf.push_back(8'($urandom_range('h20, 'h2F)));
            str_buf.push_back(8'($urandom_range('h40, 'h7E)));
        end else if (kind < 70) begin
            // escape sequence broken by an arbitrary byte
            str_buf.push_back(ESC_BYTE);
            str_buf.push_back(CSI_BYTE);
            repeat ($urandom_range(0, 3))
                str_buf.push_back(8'($urandom_range('h30, 'h3F)));
            str_buf.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 73) begin
            str_buf.push_back(ESC_BYTE);
            str_buf.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 78) begin
            // invalid lead
            if ($urandom_range(0, 1)) str_buf.push_back(8'($urandom_range('h80, 'hBF)));
            else str_buf.push_back(8'($urandom_range('hF8, 'hFF)));
        end else if (kind < 85) begin
            // continuation bytes are taken blindly
            add_lead(need);
            repeat (need) str_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
            str_buf.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task add_random_string();
        int unsigned pieces;
        int unsigned need;
        pieces = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 8) : $urandom_range(15, 40);
        repeat (pieces) add_random_piece();
        // truncated final sequence
        if ($urandom_range(0, 9) == 0) begin
            add_lead(need);
            repeat ($urandom_range(0, need - 1))
                str_buf.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task build_stimulus();
        int unsigned random_bytes;
        // single bytes at the field extremes, invalid leads
        str_buf.push_back(8'h00); send_string();
        str_buf.push_back(8'hFF); send_string();
        str_buf.push_back(8'h80); str_buf.push_back(8'h7F); send_string();
        // wide, emoji, combining marks, joiner, selector, skin tone
        add_cp(21'h4E00); add_cp(21'h1F600); send_string();
        str_buf.push_back("e"); add_cp(21'h0301); add_cp(21'h200D);
        add_cp(21'hFE0F); add_cp(21'h1F3FB); send_string();
        // escape sequence skipped, with parameter and intermediate
        str_buf.push_back(ESC_BYTE); str_buf.push_back(CSI_BYTE);
        str_buf.push_back("1"); str_buf.push_back(" "); str_buf.push_back("q");
        str_buf.push_back("x"); send_string();
        // escape without bracket
        str_buf.push_back(ESC_BYTE); str_buf.push_back("x"); send_string();
        // broken escape sequence, then unfinished at the end
        str_buf.push_back(ESC_BYTE); str_buf.push_back(CSI_BYTE);
        str_buf.push_back(8'h07); str_buf.push_back(ESC_BYTE);
        str_buf.push_back(CSI_BYTE); str_buf.push_back("3"); send_string();
        // truncated final sequence
        str_buf.push_back(8'hE4); str_buf.push_back(8'hB8); send_string();
        // largest four-byte payload
        str_buf.push_back(8'hF7); str_buf.push_back(8'hBF);
        str_buf.push_back(8'hBF); str_buf.push_back(8'hBF); send_string();

        random_bytes = 0;
        while (random_bytes < RANDOM_BYTES) begin
            add_random_string();
            random_bytes += str_buf.size();
            send_string();
        end
    endtask

    // gap after a byte beat: mostly none, some short, a few long
    function int unsigned next_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 63) == 0) calm_in = !calm_in;
        if (calm_in || r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task report_mismatch(input string what, input int unsigned got, input int unsigned want);
        $display("ERROR at %0t ns: %s: got %0d, expected %0d", $realtime, what, got, want);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // byte driver
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_beat predicted;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            // beat accepted at this edge
            if (i_in_valid && step_width(i_in_beat, predicted)) begin
                width_expected.push_back(predicted);
            end
            if (hold_off > 0) begin
                hold_off = hold_off - 1;
                i_in_valid <= 1'b0;
            end else if (byte_queue.size() > 0) begin
                i_in_beat  <= byte_queue.pop_front();
                i_in_valid <= 1'b1;
                hold_off = next_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor and output stall
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_beat want;
        int unsigned r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (width_expected.size() == 0) begin
                report_mismatch("result beat with no string pending", o_out_beat.column_width, 0);
            end else begin
                want = width_expected.pop_front();
                if (o_out_beat.column_width !== want.column_width)
                    report_mismatch("column_width", o_out_beat.column_width, want.column_width);
                if (o_out_beat.width_saturated !== want.width_saturated)
                    report_mismatch("width_saturated", o_out_beat.width_saturated,
                                    want.width_saturated);
            end
        end
        // stall runs: mostly none, some short, a few long
        if ($urandom_range(0, 127) == 0) calm_out = !calm_out;
        if (stall_left == 0 && !calm_out) begin
            r = $urandom_range(0, 99);
            if (r >= 95) stall_left = $urandom_range(10, 60);
            else if (r >= 70) stall_left = $urandom_range(1, 3);
        end
        i_out_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left = stall_left - 1;
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("utf8_display_width_counter_test: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // run control
    // ------------------------------------------------------------------
    initial begin
        clear_decoder();
        build_stimulus();
        do begin
            @(posedge i_clk);
        end while (!i_rst_n || byte_queue.size() != 0 || i_in_valid ||
                   width_expected.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (width_expected.size() != 0)
            report_mismatch("string widths never delivered", 0, width_expected.size());
        if (err_count == 0) begin
            $display("utf8_display_width_counter_test: done, clean");
        end else begin
            $display("utf8_display_width_counter_test: done, errors");
        end
        $finish;
    end

endmodule

[utf8_display_width_counter.f]
rtl/utf8dw_pkg.sv
rtl/utf8dw_in_reg.sv
rtl/utf8dw_core.sv
rtl/utf8dw_out_reg.sv
rtl/utf8_display_width_counter.sv
verif/utf8_display_width_counter_test.sv
